// ===== rtl/fatc_pkg.sv =====
// ----------------------------------------------------------------------------
// FAT timestamp converter package
// Shared constants, reciprocal factors, the month table and zone helpers.
// ----------------------------------------------------------------------------
package fatc_pkg;

  // internal pipeline stages between the input register and the output register
  localparam int NUM_STG = 6;
  typedef logic [NUM_STG-1:0] stg_en_t;

  typedef enum logic {
    KIND_TO_DOS  = 1'b0,
    KIND_TO_UNIX = 1'b1
  } kind_t;

  localparam logic signed [33:0] EPOCH_1980 = 34'sd315532800;
  localparam logic [16:0] SECS_PER_DAY      = 17'd86400;
  localparam logic [15:0] DAYS_TO_1980_LEAP = 16'd3653;
  localparam logic [8:0]  LEAP_FEB_END      = 9'd59;

  // reciprocals, rounded up, exact over the operand ranges used
  localparam logic [24:0] RECIP_675_K34 = 25'd25451659;  // 2^34 / 675
  localparam logic [15:0] RECIP_365_K24 = 16'd45965;     // 2^24 / 365
  localparam logic [15:0] RECIP_15_K19  = 16'd34953;     // 2^19 / 15
  localparam logic [9:0]  RECIP_15_K13  = 10'd547;       // 2^13 / 15

  // cumulative days before each month; indices 12 to 15 count as zero
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // zone offset in seconds
  function automatic logic signed [16:0] zone_secs(input logic signed [10:0] zone);
    logic signed [16:0] z;
    z = 17'(zone);
    return z * 17'sd60;
  endfunction

endpackage

// ===== rtl/fatc_u2d.sv =====
// ----------------------------------------------------------------------------
// Unix to DOS pipeline
// Removes the zone offset, clamps to 1980 and splits into DOS time/date words.
// ----------------------------------------------------------------------------
module fatc_u2d
  import fatc_pkg::*;
(
  input  logic               clk,
  input  stg_en_t            en,
  input  logic signed [10:0] zone,
  input  logic signed [31:0] unix_seconds_in,
  output logic [15:0]        dos_time_out,
  output logic [15:0]        dos_date_out
);

  // stage 1
  logic signed [33:0] w;
  logic [30:0] v_nxt, v_r;
  // stage 2
  logic [48:0] prod_day;
  logic [14:0] day2_nxt, day2_r;
  logic [16:0] vlo_nxt, vlo_r;
  // stage 3
  logic [31:0] day_secs;
  logic [30:0] prod_yr;
  logic [16:0] sod_nxt, sod_r;
  logic [6:0]  y_nxt, y_r;
  logic [14:0] day3_r;
  // stage 4
  logic [30:0] prod_min;
  logic [10:0] mt_nxt, mt_r;
  logic [16:0] sec_full;
  logic [5:0]  sec4_nxt, sec4_r;
  logic [7:0]  y_p3, y_p2;
  logic [6:0]  y_m1;
  logic [14:0] off1_nxt, off1_r, off0_nxt, off0_r;
  logic [14:0] day4_r;
  logic [6:0]  y4_r;
  // stage 5
  logic [18:0] prod_hr;
  logic [4:0]  hr_nxt, hr_r;
  logic [10:0] min_full;
  logic [5:0]  min_nxt, min_r;
  logic [6:0]  yr5_nxt, yr5_r;
  logic [14:0] doy_full;
  logic [8:0]  doy_nxt, doy_r;
  logic [5:0]  sec5_r;
  // stage 6
  logic        leap;
  logic [8:0]  nl_nxt, nl_r;
  logic [3:0]  mon_nxt, mon_r;
  logic [15:0] time_nxt, time_r;
  logic [6:0]  yr6_r;

  // stage 1: zone removal and clamp, offset from 1980
  always_comb begin
    w = 34'(unix_seconds_in) - 34'(zone_secs(zone));
    if (w < EPOCH_1980) begin
      v_nxt = '0;
    end else begin
      v_nxt = 31'(w - EPOCH_1980);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      v_r <= v_nxt;
    end
  end

  // stage 2: day number, v / 86400 as (v >> 7) / 675
  always_comb begin
    prod_day = 49'(v_r[30:7]) * 49'(RECIP_675_K34);
    day2_nxt = prod_day[48:34];
    vlo_nxt  = v_r[16:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      day2_r <= day2_nxt;
      vlo_r  <= vlo_nxt;
    end
  end

  // stage 3: second of day and first year estimate
  always_comb begin
    day_secs = 32'(day2_r) * 32'(SECS_PER_DAY);
    sod_nxt  = vlo_r - day_secs[16:0];
    prod_yr  = 31'(day2_r) * 31'(RECIP_365_K24);
    y_nxt    = prod_yr[30:24];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sod_r  <= sod_nxt;
      y_r    <= y_nxt;
      day3_r <= day2_r;
    end
  end

  // stage 4: minute of day, seconds, day offsets for year and year-1
  always_comb begin
    prod_min = 31'(sod_r[16:2]) * 31'(RECIP_15_K19);
    mt_nxt   = prod_min[29:19];
    sec_full = sod_r - (17'({mt_nxt, 6'b0}) - 17'({mt_nxt, 2'b0}));
    sec4_nxt = sec_full[5:0];
    y_p3     = 8'(y_r) + 8'd3;
    y_m1     = y_r - 7'd1;
    y_p2     = 8'(y_r) + 8'd2;
    off1_nxt = 15'(y_p3[7:2]) + 15'(y_r) * 15'd365;
    // only used when the estimate is at least one
    off0_nxt = 15'(y_p2[7:2]) + 15'(y_m1) * 15'd365;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      mt_r   <= mt_nxt;
      sec4_r <= sec4_nxt;
      off1_r <= off1_nxt;
      off0_r <= off0_nxt;
      day4_r <= day3_r;
      y4_r   <= y_r;
    end
  end

  // stage 5: hour and minute, year correction and day of year
  always_comb begin
    prod_hr  = 19'(mt_r[10:2]) * 19'(RECIP_15_K13);
    hr_nxt   = prod_hr[17:13];
    min_full = mt_r - (11'({hr_nxt, 6'b0}) - 11'({hr_nxt, 2'b0}));
    min_nxt  = min_full[5:0];
    if (off1_r > day4_r) begin
      yr5_nxt  = y4_r - 7'd1;
      doy_full = day4_r - off0_r;
    end else begin
      yr5_nxt  = y4_r;
      doy_full = day4_r - off1_r;
    end
    doy_nxt = doy_full[8:0];
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      hr_r   <= hr_nxt;
      min_r  <= min_nxt;
      sec5_r <= sec4_r;
      yr5_r  <= yr5_nxt;
      doy_r  <= doy_nxt;
    end
  end

  // stage 6: time word, leap day handling, month search
  always_comb begin
    time_nxt = {hr_r, min_r, sec5_r[5:1]};
    leap     = (yr5_r[1:0] == 2'b00);
    mon_nxt  = 4'd12;
    if (leap && doy_r == LEAP_FEB_END) begin
      // Feb 29
      nl_nxt  = doy_r;
      mon_nxt = 4'd2;
    end else begin
      nl_nxt = (!leap || doy_r <= LEAP_FEB_END) ? doy_r : doy_r - 9'd1;
      for (int m = 11; m >= 0; m--) begin
        if (month_start(4'(m)) > nl_nxt) begin
          mon_nxt = 4'(m);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      time_r <= time_nxt;
      nl_r   <= nl_nxt;
      mon_r  <= mon_nxt;
      yr6_r  <= yr5_r;
    end
  end

  assign dos_time_out = time_r;
  assign dos_date_out = 16'(nl_r) - 16'(month_start(mon_r - 4'd1)) + 16'd1
                      + {7'b0, mon_r, 5'b0} + {yr6_r, 9'b0};

endmodule

// ===== rtl/fatc_d2u.sv =====
// ----------------------------------------------------------------------------
// DOS to Unix pipeline
// Turns DOS time/date words into Unix seconds, adds the zone offset.
// ----------------------------------------------------------------------------
module fatc_d2u
  import fatc_pkg::*;
(
  input  logic               clk,
  input  stg_en_t            en,
  input  logic signed [10:0] zone,
  input  logic [15:0]        dos_time_in,
  input  logic [15:0]        dos_date_in,
  output logic signed [31:0] unix_seconds_out
);

  logic [3:0]  midx;
  logic [6:0]  yr;
  logic        feb_adj;
  logic [15:0] days_nxt, days_r;
  logic [16:0] tsec_nxt, tsec1_r, tsec2_r;
  logic [32:0] prod_days;
  logic [31:0] dsec_nxt, dsec_r;
  logic [31:0] res_nxt, res3_r, res4_r, res5_r, res6_r;

  // stage 1: day count since 1970 and seconds of day
  always_comb begin
    midx    = dos_date_in[8:5] - 4'd1;
    yr      = dos_date_in[15:9];
    feb_adj = (yr[1:0] == 2'b00) && (midx < 4'd2);
    days_nxt = 16'(dos_date_in[4:0]) + 16'(month_start(midx)) + 16'(yr[6:2])
             + 16'(yr) * 16'd365 + DAYS_TO_1980_LEAP - 16'd1 - 16'(feb_adj);
    tsec_nxt = 17'({dos_time_in[4:0], 1'b0}) + 17'(dos_time_in[10:5]) * 17'd60
             + 17'(dos_time_in[15:11]) * 17'd3600;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      days_r  <= days_nxt;
      tsec1_r <= tsec_nxt;
    end
  end

  // stage 2: days to seconds
  always_comb begin
    prod_days = 33'(days_r) * 33'(SECS_PER_DAY);
    dsec_nxt  = prod_days[31:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dsec_r  <= dsec_nxt;
      tsec2_r <= tsec1_r;
    end
  end

  // stage 3: final sum, wraps at 32 bits
  assign res_nxt = dsec_r + 32'(tsec2_r) + 32'(zone_secs(zone));

  // stages 3 to 6 register the result to line up with the Unix to DOS side
  always_ff @(posedge clk) begin
    if (en[2]) begin
      res3_r <= res_nxt;
    end
    if (en[3]) begin
      res4_r <= res3_r;
    end
    if (en[4]) begin
      res5_r <= res4_r;
    end
    if (en[5]) begin
      res6_r <= res5_r;
    end
  end

  assign unix_seconds_out = res6_r;

endmodule

// ===== rtl/fat_timestamp_converter.sv =====
// ----------------------------------------------------------------------------
// FAT timestamp converter
// Unix seconds to and from FAT (DOS) time/date words, one request per clock unless the result side stalls.
// ----------------------------------------------------------------------------
// Takes one request per clock and sustains one result per clock while
// out_tready stays high. A request spends 8 register stages from input to
// output (input register, six pipeline stages, output register) before its
// result shows on out_tvalid. The depth is set by the Unix to DOS path, where
// each reciprocal multiplier (days, years, minutes, hours) gets a stage of
// its own. Ready ripples back stage by stage, so empty stages keep taking
// requests while a result waits at the output. zone_minutes_west is written
// through cfg_we/cfg_wdata and must only change while the block is idle.
module fat_timestamp_converter
  import fatc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,     // zone_minutes_west
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,      // unix_seconds_in, dos_time_in, dos_date_in
  input  logic        in_tuser,      // kind
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata      // unix_seconds_out, dos_time_out, dos_date_out
);

  logic signed [10:0] zone_r;
  logic [NUM_STG:0]   vld_r;
  logic [NUM_STG+1:0] rdy;
  kind_t              kind_r [NUM_STG+1];
  logic signed [31:0] unix_in_r;
  logic [15:0]        dos_time_in_r;
  logic [15:0]        dos_date_in_r;
  stg_en_t            en;
  logic [15:0]        u2d_time;
  logic [15:0]        u2d_date;
  logic signed [31:0] d2u_unix;
  logic               out_valid_r;
  logic [63:0]        out_data_nxt, out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= '0;
    end else if (cfg_we) begin
      zone_r <= cfg_wdata;
    end
  end

  // a stage may load when it is empty or the stage after it loads
  always_comb begin
    rdy[NUM_STG+1] = !out_valid_r || out_tready;
    for (int k = NUM_STG; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];
  assign en        = rdy[NUM_STG:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k <= NUM_STG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (rdy[NUM_STG+1]) begin
        out_valid_r <= vld_r[NUM_STG];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      kind_r[0]     <= kind_t'(in_tuser);
      unix_in_r     <= in_tdata[31:0];
      dos_time_in_r <= in_tdata[47:32];
      dos_date_in_r <= in_tdata[63:48];
    end
    for (int k = 1; k <= NUM_STG; k++) begin
      if (rdy[k]) begin
        kind_r[k] <= kind_r[k-1];
      end
    end
  end

  fatc_u2d u_u2d (
    .clk             (clk),
    .en              (en),
    .zone            (zone_r),
    .unix_seconds_in (unix_in_r),
    .dos_time_out    (u2d_time),
    .dos_date_out    (u2d_date)
  );

  fatc_d2u u_d2u (
    .clk              (clk),
    .en               (en),
    .zone             (zone_r),
    .dos_time_in      (dos_time_in_r),
    .dos_date_in      (dos_date_in_r),
    .unix_seconds_out (d2u_unix)
  );

  // fields of the other direction read as zero
  always_comb begin
    if (kind_r[NUM_STG] == KIND_TO_UNIX) begin
      out_data_nxt = {32'b0, d2u_unix};
    end else begin
      out_data_nxt = {u2d_date, u2d_time, 32'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NUM_STG+1]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/fatc_chk.sv =====
// ----------------------------------------------------------------------------
// FAT timestamp converter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module fatc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset empties the pipeline and opens the request side
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  // a DOS result carries a month in 1..12 and no Unix field
  a_dos_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[63:48] != 16'd0 |->
      out_tdata[56:53] != 4'd0 && out_tdata[56:53] <= 4'd12 &&
      out_tdata[31:0] == 32'd0)
    else $error("malformed DOS date result");

  // hour field never exceeds 23
  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:43] < 5'd24)
    else $error("hour out of range");

endmodule

bind fat_timestamp_converter fatc_chk u_fatc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
